// ===== hdl/tcvf_pkg.sv =====
// tcvf_pkg: shared types, codes and level tables for the two-channel volume fader
// no dependencies; imported by every module of the block
`default_nettype none

package tcvf_pkg;

  // input item as seen on the push side
  typedef struct packed {
    logic [1:0] func;
    logic       chan;
  } item_t;

  // result item as seen on the pop side
  typedef struct packed {
    logic               out_chan;
    logic signed [11:0] out_volume;
    logic               stop_play;
    logic               last;
  } result_t;

  // input selector codes
  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_FADE_OUT = 2'd1;
  localparam logic [1:0] FUNC_FADE_IN  = 2'd2;

  // configuration register indexes
  localparam logic REG_LEVEL_CH0 = 1'b0;
  localparam logic REG_LEVEL_CH1 = 1'b1;

  localparam logic [3:0] LEVEL_INDEX_RESET = 4'd9;

  // fade flag bits
  localparam int FLAG_OUT_CH0 = 0;
  localparam int FLAG_OUT_CH1 = 1;
  localparam int FLAG_IN_CH0  = 2;
  localparam int FLAG_IN_CH1  = 3;

  localparam logic signed [11:0] VOL_FULL_DOWN = -12'sd990;
  localparam logic signed [11:0] VOL_STOP_EDGE = -12'sd300;

  // classified command passed from front to back
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_FADE_OUT = 2'd1,
    OP_FADE_IN  = 2'd2
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic     chan;
  } op_t;

  // back status for checking
  typedef struct packed {
    logic [3:0] flags;
    logic       busy;
  } back_status_t;

  // level = index * 110, index above 9 treated as 9
  function automatic logic signed [11:0] level_of(input logic [3:0] idx);
    logic signed [11:0] lv;
    unique case (idx)
      4'd0:    lv = 12'sd0;
      4'd1:    lv = 12'sd110;
      4'd2:    lv = 12'sd220;
      4'd3:    lv = 12'sd330;
      4'd4:    lv = 12'sd440;
      4'd5:    lv = 12'sd550;
      4'd6:    lv = 12'sd660;
      4'd7:    lv = 12'sd770;
      4'd8:    lv = 12'sd880;
      default: lv = 12'sd990;
    endcase
    return lv;
  endfunction

  // fade-out step (level-300)/90, truncated toward zero
  function automatic logic signed [7:0] out_step(input logic [3:0] idx);
    logic signed [7:0] st;
    unique case (idx)
      4'd0:    st = -8'sd3;
      4'd1:    st = -8'sd2;
      4'd2:    st = 8'sd0;
      4'd3:    st = 8'sd0;
      4'd4:    st = 8'sd1;
      4'd5:    st = 8'sd2;
      4'd6:    st = 8'sd4;
      4'd7:    st = 8'sd5;
      4'd8:    st = 8'sd6;
      default: st = 8'sd7;
    endcase
    return st;
  endfunction

  // fade-in step level/90
  function automatic logic signed [7:0] in_step(input logic [3:0] idx);
    logic signed [7:0] st;
    unique case (idx)
      4'd0:    st = 8'sd0;
      4'd1:    st = 8'sd1;
      4'd2:    st = 8'sd2;
      4'd3:    st = 8'sd3;
      4'd4:    st = 8'sd4;
      4'd5:    st = 8'sd6;
      4'd6:    st = 8'sd7;
      4'd7:    st = 8'sd8;
      4'd8:    st = 8'sd9;
      default: st = 8'sd11;
    endcase
    return st;
  endfunction

  // volume plus or minus a step, saturated to the 12-bit range
  function automatic logic signed [11:0] vol_move(input logic signed [11:0] cur,
                                                  input logic signed [7:0]  st,
                                                  input logic               down);
    logic signed [12:0] a;
    logic signed [12:0] b;
    logic signed [12:0] s;
    logic signed [11:0] r;
    a = {cur[11], cur};
    b = {{5{st[7]}}, st};
    s = down ? (a - b) : (a + b);
    if (s[12] != s[11]) begin
      r = s[12] ? 12'sh800 : 12'sh7ff;
    end else begin
      r = s[11:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tcvf_front.sv =====
// tcvf_front: accepts input items, classifies them and queues commands for the back
// depends on tcvf_pkg
`default_nettype none

module tcvf_front
  import tcvf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  output logic       full,
  input  wire item_t item,
  output logic       op_valid,
  output op_t        op,
  input  wire logic  op_take
);

  op_t        q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       keep;
  op_t        op_new;

  // classify; selector 3 is accepted and dropped
  always_comb begin
    op_new.chan = item.chan;
    keep        = 1'b1;
    unique case (item.func)
      FUNC_TICK:     op_new.kind = OP_TICK;
      FUNC_FADE_OUT: op_new.kind = OP_FADE_OUT;
      FUNC_FADE_IN:  op_new.kind = OP_FADE_IN;
      default: begin
        op_new.kind = OP_TICK;
        keep        = 1'b0;
      end
    endcase
  end

  assign full     = (count == 2'd2);
  assign accept   = push && !full;
  assign op_valid = (count != 2'd0);
  assign op       = q[rd_ptr];

  // queue pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept && keep) begin
        wr_ptr <= ~wr_ptr;
      end
      if (op_take && op_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, accept && keep} - {1'b0, op_take && op_valid};
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (accept && keep) begin
      q[wr_ptr] <= op_new;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tcvf_back.sv =====
// tcvf_back: fade state, command execution and result buffer for the volume fader
// depends on tcvf_pkg
`default_nettype none

module tcvf_back
  import tcvf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   op_valid,
  input  wire op_t    op,
  output logic        op_take,
  input  wire logic   wr_en,
  input  wire logic   wr_index,
  input  wire [3:0]   wr_data,
  output logic        empty,
  input  wire logic   pop,
  output result_t     result,
  output back_status_t status
);

  logic [3:0]         idx0;
  logic [3:0]         idx1;
  logic [3:0]         flags;
  logic [3:0]         flags_next;
  logic signed [7:0]  step0;
  logic signed [7:0]  step0_next;
  logic signed [7:0]  step1;
  logic signed [7:0]  step1_next;
  logic signed [11:0] cur0;
  logic signed [11:0] cur0_next;
  logic signed [11:0] cur1;
  logic signed [11:0] cur1_next;
  logic signed [11:0] lv0;
  logic signed [11:0] lv1;
  logic [1:0]         outs;
  logic [1:0]         ins;
  result_t            slot [4];
  result_t            slot_new [4];
  logic [3:0]         mask;
  logic [3:0]         mask_new;
  logic [3:0]         head;
  logic [1:0]         head_sel;
  logic               is_tick;

  assign lv0  = level_of(idx0);
  assign lv1  = level_of(idx1);
  assign outs = flags[1:0];
  assign ins  = flags[3:2];

  // a tick waits for the result buffer to drain; start commands never do
  assign is_tick = (op.kind == OP_TICK);
  assign op_take = op_valid && (!is_tick || (mask == 4'd0));

  // execute one command
  always_comb begin
    flags_next = flags;
    step0_next = step0;
    step1_next = step1;
    cur0_next  = cur0;
    cur1_next  = cur1;
    mask_new   = 4'd0;
    for (int i = 0; i < 4; i++) begin
      slot_new[i] = '0;
    end
    unique case (op.kind)
      OP_FADE_OUT: begin
        if (ins == 2'b00) begin
          if (!op.chan && outs != 2'b01) begin
            flags_next[FLAG_OUT_CH0] = 1'b1;
            step0_next = out_step(idx0);
            cur0_next  = lv0 + VOL_FULL_DOWN;
          end
          if (op.chan && outs != 2'b10) begin
            flags_next[FLAG_OUT_CH1] = 1'b1;
            step1_next = out_step(idx1);
            cur1_next  = lv1 + VOL_FULL_DOWN;
          end
        end
      end
      OP_FADE_IN: begin
        if (outs == 2'b00 && op.chan && ins != 2'b10) begin
          flags_next[FLAG_IN_CH1] = 1'b1;
          step1_next = in_step(idx1);
          cur1_next  = VOL_FULL_DOWN;
        end
      end
      default: begin
        if (outs != 2'b00) begin
          // fade-outs step down, end below the stop edge
          if (flags[FLAG_OUT_CH0]) begin
            cur0_next = vol_move(cur0, step0, 1'b1);
          end
          if (flags[FLAG_OUT_CH1]) begin
            cur1_next = vol_move(cur1, step1, 1'b1);
          end
          mask_new[0] = flags[FLAG_OUT_CH0];
          mask_new[1] = flags[FLAG_OUT_CH1];
          mask_new[2] = flags[FLAG_OUT_CH0] && (cur0_next < VOL_STOP_EDGE);
          mask_new[3] = flags[FLAG_OUT_CH1] && (cur1_next < VOL_STOP_EDGE);
          slot_new[2].out_volume = lv0 + VOL_FULL_DOWN;
          slot_new[3].out_volume = lv1 + VOL_FULL_DOWN;
          slot_new[2].stop_play  = 1'b1;
          slot_new[3].stop_play  = 1'b1;
          if (mask_new[2]) begin
            flags_next[FLAG_OUT_CH0] = 1'b0;
          end
          if (mask_new[3]) begin
            flags_next[FLAG_OUT_CH1] = 1'b0;
          end
        end else if (ins != 2'b00) begin
          // fade-ins step up, end above the level
          if (flags[FLAG_IN_CH0]) begin
            cur0_next = vol_move(cur0, step0, 1'b0);
          end
          if (flags[FLAG_IN_CH1]) begin
            cur1_next = vol_move(cur1, step1, 1'b0);
          end
          mask_new[0] = flags[FLAG_IN_CH0];
          mask_new[1] = flags[FLAG_IN_CH1];
          mask_new[2] = flags[FLAG_IN_CH0] && (cur0_next > lv0);
          mask_new[3] = flags[FLAG_IN_CH1] && (cur1_next > lv1);
          slot_new[2].out_volume = lv0;
          slot_new[3].out_volume = lv1;
          if (mask_new[2]) begin
            flags_next[FLAG_IN_CH0] = 1'b0;
          end
          if (mask_new[3]) begin
            flags_next[FLAG_IN_CH1] = 1'b0;
          end
        end
        slot_new[0].out_volume = cur0_next;
        slot_new[1].out_volume = cur1_next;
        slot_new[0].out_chan   = 1'b0;
        slot_new[1].out_chan   = 1'b1;
        slot_new[2].out_chan   = 1'b0;
        slot_new[3].out_chan   = 1'b1;
      end
    endcase
  end

  // oldest pending result is the lowest set mask bit
  always_comb begin
    head     = 4'd0;
    head_sel = 2'd0;
    priority if (mask[0]) begin
      head[0]  = 1'b1;
      head_sel = 2'd0;
    end else if (mask[1]) begin
      head[1]  = 1'b1;
      head_sel = 2'd1;
    end else if (mask[2]) begin
      head[2]  = 1'b1;
      head_sel = 2'd2;
    end else if (mask[3]) begin
      head[3]  = 1'b1;
      head_sel = 2'd3;
    end
  end

  assign empty = (mask == 4'd0);

  always_comb begin
    result      = slot[head_sel];
    result.last = ((mask & ~head) == 4'd0);
  end

  assign status.flags = flags;
  assign status.busy  = !empty;

  // control and fade state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx0  <= LEVEL_INDEX_RESET;
      idx1  <= LEVEL_INDEX_RESET;
      flags <= 4'd0;
      step0 <= '0;
      step1 <= '0;
      cur0  <= '0;
      cur1  <= '0;
      mask  <= 4'd0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_LEVEL_CH0: idx0 <= wr_data;
          REG_LEVEL_CH1: idx1 <= wr_data;
          default:       idx1 <= wr_data;
        endcase
      end
      if (op_take) begin
        flags <= flags_next;
        step0 <= step0_next;
        step1 <= step1_next;
        cur0  <= cur0_next;
        cur1  <= cur1_next;
      end
      if (op_take && is_tick) begin
        mask <= mask_new;
      end else if (pop && !empty) begin
        mask <= mask & ~head;
      end
    end
  end

  // result slots, loaded by a tick
  always_ff @(posedge clk) begin
    if (op_take && is_tick) begin
      for (int i = 0; i < 4; i++) begin
        slot[i] <= slot_new[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/two_channel_volume_fader.sv =====
// two_channel_volume_fader: top level, front command queue plus back fade engine
// depends on tcvf_pkg, tcvf_front, tcvf_back
//
//   channel  | handshake        | payload
//   ---------+------------------+--------------------------------------------
//   input    | push / full      | item   (func, chan)
//   result   | pop / empty      | result (out_chan, out_volume, stop_play, last)
//   config   | wr_en            | wr_index, wr_data (level index per channel)
//
// a command goes from push to the back through a registered two-entry queue
// a tick computes all of its results at once into the result buffer, which
// then delivers one per cycle while pop is held; a tick gives up to 4 results
// a tick waits while results of the previous tick remain; starts do not
// rst is synchronous: clears both queues and fade state, level indexes go to 9
`default_nettype none

module two_channel_volume_fader
  import tcvf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  output logic        full,
  input  wire item_t  item,
  output logic        empty,
  input  wire logic   pop,
  output result_t     result,
  input  wire logic   wr_en,
  input  wire logic   wr_index,
  input  wire [3:0]   wr_data
);

  logic         op_valid;
  op_t          op;
  logic         op_take;
  back_status_t status;

  // command intake
  tcvf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .item     (item),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take)
  );

  // fade engine and result buffer
  tcvf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .op_take  (op_take),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .status   (status)
  );

  // fade-outs and fade-ins never run together
  assert property (@(posedge clk) disable iff (rst)
    !((status.flags[FLAG_OUT_CH0] || status.flags[FLAG_OUT_CH1]) &&
      (status.flags[FLAG_IN_CH0] || status.flags[FLAG_IN_CH1])))
    else $error("fade-out and fade-in active at once");

  // channel 0 never fades in
  assert property (@(posedge clk) disable iff (rst) !status.flags[FLAG_IN_CH0])
    else $error("fade-in flag set on channel 0");

  // a stop transfer restores level-990, never above zero
  assert property (@(posedge clk) disable iff (rst)
    (!empty && result.stop_play) |-> (result.out_volume <= 12'sd0))
    else $error("stop transfer with positive volume");

  // a transfer of a non-final result leaves more results pending
  assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !result.last) |=> !empty)
    else $error("results lost after non-final transfer");

endmodule

`default_nettype wire
